@@ rtl/smthd_pkg.sv @@
// Shared widths, reset values, register indexes and the value request type.
`timescale 1ns / 1ps

package smthd_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int SMOOTH_BITS    = SAMPLE_BITS + 2;
	localparam int INDEX_BITS     = 20;
	localparam int CFG_INDEX_BITS = 2;
	localparam int OUT_DATA_BITS  = 80;

	localparam logic signed [SMOOTH_BITS-1:0] HIGH_RESET = SMOOTH_BITS'(10045);
	localparam logic signed [SMOOTH_BITS-1:0] LOW_RESET  = SMOOTH_BITS'(5120);
	localparam logic [INDEX_BITS-1:0]         INDEX_MAX  = '1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_THRESHOLD = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_THRESHOLD  = CFG_INDEX_BITS'(1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SMOOTH_BITS-1:0] smooth_t;
	typedef logic [INDEX_BITS-1:0]         index_t;

	// One smoothed value on its way from the filter to the detector.
	typedef struct packed {
		smooth_t value;
		logic    last;
	} smthd_val_t;

endpackage

@@ rtl/smthd_filter.sv @@
// 1-2-1 smoothing filter with edge weights and a two-entry result buffer.
`timescale 1ns / 1ps

module smthd_filter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  smthd_pkg::sample_t    in_sample,
	input  logic                  in_last,
	output logic                  val_valid,
	input  logic                  val_ready,
	output smthd_pkg::smthd_val_t val
);
	import smthd_pkg::*;

	sample_t prior_q;
	sample_t held_q;
	logic    held_valid_q;
	logic    held_is_first_q;

	logic    pend0_s1;
	logic    pend1_s1;
	smooth_t val0_s1;
	logic    end0_s1;
	smooth_t val1_s1;

	smooth_t cur_ext;
	smooth_t held_ext;
	smooth_t prior_ext;
	smooth_t mid_sum;
	smooth_t end_sum;
	smooth_t lone_sum;
	logic    accept;
	logic    take;

	assign cur_ext   = SMOOTH_BITS'(in_sample);
	assign held_ext  = SMOOTH_BITS'(held_q);
	assign prior_ext = SMOOTH_BITS'(prior_q);

	// Sums of quarter weights stay within the Q8.10 range.
	assign mid_sum  = held_is_first_q ? (held_ext <<< 1) + held_ext + cur_ext
	                                  : prior_ext + (held_ext <<< 1) + cur_ext;
	assign end_sum  = held_ext + (cur_ext <<< 1) + cur_ext;
	assign lone_sum = cur_ext <<< 2;

	assign val_valid = pend0_s1 | pend1_s1;
	assign take      = val_valid & val_ready;
	assign in_ready  = !val_valid || (val_ready && (pend0_s1 ^ pend1_s1));
	assign accept    = in_valid & in_ready;

	always_comb begin
		if (pend0_s1) begin
			val.value = val0_s1;
			val.last  = end0_s1;
		end else begin
			val.value = val1_s1;
			val.last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q         <= '0;
			held_q          <= '0;
			held_valid_q    <= 1'b0;
			held_is_first_q <= 1'b1;
			pend0_s1        <= 1'b0;
			pend1_s1        <= 1'b0;
		end else begin
			if (take) begin
				if (pend0_s1) begin
					pend0_s1 <= 1'b0;
				end else begin
					pend1_s1 <= 1'b0;
				end
			end
			if (accept) begin
				if (!in_last) begin
					if (held_valid_q) begin
						pend0_s1        <= 1'b1;
						held_is_first_q <= 1'b0;
					end
					prior_q      <= held_q;
					held_q       <= in_sample;
					held_valid_q <= 1'b1;
				end else begin
					pend0_s1        <= 1'b1;
					pend1_s1        <= held_valid_q;
					prior_q         <= '0;
					held_q          <= '0;
					held_valid_q    <= 1'b0;
					held_is_first_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val0_s1 <= (in_last && !held_valid_q) ? lone_sum : mid_sum;
			end0_s1 <= in_last && !held_valid_q;
			val1_s1 <= end_sum;
		end
	end

	a_hold_after_middle : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_last) |=> held_valid_q)
		else $error("held sample not kept after a middle request");

	a_clear_after_last : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |=> (!held_valid_q && held_is_first_q))
		else $error("filter state not cleared after the final request");

	a_no_accept_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		(pend0_s1 && pend1_s1) |-> !in_ready)
		else $error("request accepted while two results are pending");

endmodule

@@ rtl/smthd_detect.sv @@
// Hysteresis detector, running peak and index counter with the output register.
`timescale 1ns / 1ps

module smthd_detect (
	input  logic                  clk,
	input  logic                  arst_n,
	input  smthd_pkg::smooth_t    high_threshold,
	input  smthd_pkg::smooth_t    low_threshold,
	input  logic                  val_valid,
	output logic                  val_ready,
	input  smthd_pkg::smthd_val_t val,
	output logic                  out_valid,
	input  logic                  out_ready,
	output smthd_pkg::smooth_t    smoothed,
	output smthd_pkg::index_t     sample_index,
	output logic                  exceed_event,
	output smthd_pkg::smooth_t    peak_value,
	output smthd_pkg::index_t     peak_index,
	output logic                  end_of_run
);
	import smthd_pkg::*;

	index_t  emit_count_q;
	logic    armed_q;
	smooth_t peak_q;
	index_t  peak_pos_q;
	logic    out_valid_q;

	logic    take;
	logic    hit;
	logic    event_now;
	logic    armed_next;
	logic    new_peak;
	smooth_t peak_next;
	index_t  pos_next;

	assign val_ready = !out_valid_q || out_ready;
	assign take      = val_valid & val_ready;
	assign out_valid = out_valid_q;

	assign hit       = val.value >= high_threshold;
	assign event_now = hit && armed_q;
	assign new_peak  = peak_q < val.value;
	assign peak_next = new_peak ? val.value : peak_q;
	assign pos_next  = new_peak ? emit_count_q : peak_pos_q;

	always_comb begin
		armed_next = armed_q;
		priority if (hit) begin
			if (armed_q) begin
				armed_next = 1'b0;
			end
		end else if (val.value <= low_threshold) begin
			armed_next = 1'b1;
		end else begin
			armed_next = armed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_count_q <= '0;
			armed_q      <= 1'b1;
			peak_q       <= '0;
			peak_pos_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (val.last) begin
					emit_count_q <= '0;
					armed_q      <= 1'b1;
					peak_q       <= '0;
					peak_pos_q   <= '0;
				end else begin
					if (emit_count_q != INDEX_MAX) begin
						emit_count_q <= emit_count_q + INDEX_BITS'(1);
					end
					armed_q    <= armed_next;
					peak_q     <= peak_next;
					peak_pos_q <= pos_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			smoothed     <= val.value;
			sample_index <= emit_count_q;
			exceed_event <= event_now;
			peak_value   <= peak_next;
			peak_index   <= pos_next;
			end_of_run   <= val.last;
		end
	end

	a_clear_after_end : assert property (@(posedge clk) disable iff (!arst_n)
		(take && val.last) |=> (emit_count_q == '0 && armed_q))
		else $error("detector state not cleared after the final value");

	a_peak_not_negative : assert property (@(posedge clk) disable iff (!arst_n)
		!peak_q[SMOOTH_BITS-1])
		else $error("running peak fell below zero");

	a_event_disarms : assert property (@(posedge clk) disable iff (!arst_n)
		(take && event_now && !val.last) |=> !armed_q)
		else $error("detector still armed after an event");

endmodule

@@ rtl/smoothed_threshold_detector.sv @@
// Top level of the smoothed threshold detector: config registers and stream ports.
`timescale 1ns / 1ps

// Smoothed threshold detector.
// Input stream (s_*): one signed Q8.8 sample per request, s_tlast on the final
// sample of a run. Output stream (m_*): smoothed Q8.10 values with index,
// exceed event and running peak; m_tlast marks the result of the final sample.
// A run's first sample gives no result; each later sample gives the result of
// its predecessor, and the final sample gives two (predecessor and itself).
// A lone sample gives one result, the sample itself in Q8.10.
// A result reaches m_tvalid through the filter buffer, then the detector
// output register.
// Throughput: one request per cycle while the output is not stalled; a final
// sample that gives two results holds s_tready low until its first result is taken.
// When the receiver stalls, the output register holds and the filter buffer
// keeps its pending values, so s_tready drops; nothing is dropped.
// Reset clears all run state and loads the default thresholds (9.81 and 5.0).
// Write the thresholds through cfg_we/cfg_index/cfg_data only while idle;
// indexes beyond the two registers are ignored.
module smoothed_threshold_detector (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [15:0]                            s_tdata, // [15:0] sample
	input  logic                                   s_tlast, // last_sample
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [17:0] smoothed, [37:18] sample_index, [38] exceed_event,
	// [56:39] peak_value, [76:57] peak_index, [79:77] zero
	output logic [smthd_pkg::OUT_DATA_BITS-1:0]    m_tdata,
	output logic                                   m_tlast, // end_of_run
	input  logic                                   cfg_we,
	input  logic [smthd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [smthd_pkg::SMOOTH_BITS-1:0]      cfg_data
);
	import smthd_pkg::*;

	smooth_t    high_q;
	smooth_t    low_q;
	logic       val_valid;
	logic       val_ready;
	smthd_val_t val;
	smooth_t    smoothed;
	index_t     sample_index;
	logic       exceed_event;
	smooth_t    peak_value;
	index_t     peak_index;

	// Threshold registers; writes to unused indexes drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= HIGH_RESET;
			low_q  <= LOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HIGH_THRESHOLD: high_q <= cfg_data;
				REG_LOW_THRESHOLD:  low_q  <= cfg_data;
				default:            ;
			endcase
		end
	end

	// Filter: hold the last two samples and buffer up to two smoothed values.
	smthd_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata),
		.in_last   (s_tlast),
		.val_valid (val_valid),
		.val_ready (val_ready),
		.val       (val)
	);

	// Detector: advance index, hysteresis and peak per value, register the result.
	smthd_detect u_detect (
		.clk            (clk),
		.arst_n         (arst_n),
		.high_threshold (high_q),
		.low_threshold  (low_q),
		.val_valid      (val_valid),
		.val_ready      (val_ready),
		.val            (val),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.smoothed       (smoothed),
		.sample_index   (sample_index),
		.exceed_event   (exceed_event),
		.peak_value     (peak_value),
		.peak_index     (peak_index),
		.end_of_run     (m_tlast)
	);

	// Pack the result fields, lowest field first, zero fill to whole bytes.
	assign m_tdata = {3'b000, peak_index, peak_value, exceed_event, sample_index, smoothed};

endmodule
